// File: src/gsct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the gap size correction table.
// Depends on nothing; the top level and the checker import it.
package gsct_pkg;

  // Command and result-kind codes.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_CONTIG   = 3'd0;
  localparam logic [2:0] REG_READ     = 3'd1;
  localparam logic [2:0] REG_MAX_GAP  = 3'd2;
  localparam logic [2:0] REG_MIN_GAP  = 3'd3;
  localparam logic [2:0] REG_MEAN     = 3'd4;
  localparam logic [2:0] REG_DIST_LEN = 3'd5;

  localparam int ADDR_W   = 5;
  localparam int WNUM_W   = 64;  // window weighted sum
  localparam int WSUM_W   = 48;  // window weight sum
  localparam int EST_W    = 32;  // estimates and query gap
  localparam int RG_W     = 24;  // real gap result
  localparam int MU_EXP   = 40;  // mu magnitude saturates at 2^MU_EXP
  localparam int CALC_W   = 48;  // signed width for estimate arithmetic

  typedef struct packed {
    logic [1:0]         command;
    logic [13:0]        weight_index;
    logic [31:0]        weight_value;
    logic signed [31:0] query_gap;
  } gsct_in_t;

  typedef struct packed {
    logic [1:0]         done_kind;
    logic signed [23:0] real_gap;
  } gsct_out_t;

endpackage

// File: src/gap_size_correction_table_top.sv
`timescale 1ns / 1ps
// Top level of the gap size correction table: weight and estimate memories,
// command sequencer and register port. Depends on gsct_pkg and gsct_div.
//
// Usage: load weights one beat each (command 0), then send one build beat
// (command 1), then query beats (command 2); every beat returns one result
// beat. A build reads, multiplies and accumulates each weight index of the
// first window, then for every table entry does the memory reads, window
// update and write-back and runs the bit-serial divider (an entry with an
// empty window skips the divider). A query below the minimum needs no table
// reads; above the maximum it scans entries down from the top of the table;
// inside the range it runs halving steps, walks the run of equal estimates
// and uses the divider for the average. Neither memory has reset values:
// weights must be loaded before the build reads them, and the table must be
// built before it is queried. The user must write registers only while the
// block is idle; the block itself does not enforce it.
module gap_size_correction_table_top #(
  parameter int GAP_DEPTH  = 16384,
  parameter int DIST_DEPTH = 16384,
  parameter int FRAC_BITS  = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gsct_pkg::gsct_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gsct_pkg::gsct_out_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gsct_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import gsct_pkg::*;

  localparam int GW  = $clog2(GAP_DEPTH);
  localparam int DW  = $clog2(DIST_DEPTH);
  localparam int CW  = ((GW > 14) ? GW : 14) + 1;
  localparam int IW  = ((CW > 16) ? CW : 16) + 1;
  localparam int NW  = WNUM_W + FRAC_BITS;
  localparam int SW  = 2 * CW;
  localparam int PW  = IW + 32;

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_SUM_RD     = 5'd1;
  localparam logic [4:0] S_SUM_MUL    = 5'd2;
  localparam logic [4:0] S_SUM_ACC    = 5'd3;
  localparam logic [4:0] S_EST        = 5'd4;
  localparam logic [4:0] S_DIV_WAIT   = 5'd5;
  localparam logic [4:0] S_EST_CALC   = 5'd6;
  localparam logic [4:0] S_EST_WR     = 5'd7;
  localparam logic [4:0] S_SL_LO      = 5'd8;
  localparam logic [4:0] S_SL_HI      = 5'd9;
  localparam logic [4:0] S_SL_MUL     = 5'd10;
  localparam logic [4:0] S_SL_ACC     = 5'd11;
  localparam logic [4:0] S_Q_SCAN_RD  = 5'd12;
  localparam logic [4:0] S_Q_SCAN_CK  = 5'd13;
  localparam logic [4:0] S_Q_SRCH_RD  = 5'd14;
  localparam logic [4:0] S_Q_SRCH_CK  = 5'd15;
  localparam logic [4:0] S_Q_KEY_RD   = 5'd16;
  localparam logic [4:0] S_Q_KEY_CK   = 5'd17;
  localparam logic [4:0] S_Q_DN_RD    = 5'd18;
  localparam logic [4:0] S_Q_DN_CK    = 5'd19;
  localparam logic [4:0] S_Q_UP_RD    = 5'd20;
  localparam logic [4:0] S_Q_UP_CK    = 5'd21;
  localparam logic [4:0] S_Q_AVG      = 5'd22;
  localparam logic [4:0] S_Q_AVG_WAIT = 5'd23;
  localparam logic [4:0] S_RESP       = 5'd24;

  // Configuration registers.
  logic [15:0] contig_length;
  logic [15:0] read_length;
  logic [13:0] max_gap_size;
  logic [15:0] min_gap_size;
  logic [15:0] mean_insert;
  logic [14:0] dist_length;

  // Memories.
  logic [31:0]        wmem [DIST_DEPTH];
  logic [EST_W-1:0]   emem [GAP_DEPTH];
  logic               w_we;
  logic [DW-1:0]      w_waddr;
  logic [DW-1:0]      w_raddr;
  logic [31:0]        w_rdata;
  logic               e_we;
  logic [GW-1:0]      e_raddr;
  logic [EST_W-1:0]   e_rdata;

  // Sequencer state.
  logic [4:0]              state;
  logic                    in_fire;
  logic [1:0]              cmd;
  logic signed [RG_W-1:0]  res;
  logic signed [EST_W-1:0] q;
  logic signed [EST_W-1:0] min_est;
  logic signed [EST_W-1:0] max_est;
  logic [WNUM_W-1:0]       wnum;
  logic [WSUM_W-1:0]       wsum;
  logic [CW-1:0]           g;
  logic [15:0]             si;
  logic [31:0]             wl;
  logic [31:0]             wh;
  logic                    lo_ok;
  logic                    hi_ok;
  logic [PW-1:0]           prod_lo;
  logic [PW-1:0]           prod_hi;
  logic                    mu_neg;
  logic [MU_EXP:0]         mu_mag;
  logic signed [EST_W-1:0] est;
  logic [CW-1:0]           lo_q;
  logic [CW-1:0]           hi_q;
  logic [CW-1:0]           mid_r;
  logic [CW-1:0]           ci;
  logic [EST_W-1:0]        key;
  logic [SW-1:0]           run_sum;
  logic [CW-1:0]           run_cnt;

  // Divider interface.
  logic              div_start;
  logic [NW-1:0]     div_num;
  logic [WSUM_W-1:0] div_den;
  logic              div_done;
  logic [NW-1:0]     div_quot;

  // Derived values.
  logic [CW-1:0]           tab_len;
  logic [CW-1:0]           len_ext;
  logic [16:0]             dist_lim;
  logic [15:0]             sum_last;
  logic                    sum_empty;
  logic [IW-1:0]           lo_idx;
  logic [IW-1:0]           hi_idx;
  logic                    lo_valid;
  logic                    hi_valid;
  logic [CW:0]             mid_sum;
  logic [CW-1:0]           mid;
  logic [WNUM_W-1:0]       num_mag;
  logic                    den_pos;
  logic [MU_EXP:0]         mu_sat;
  logic signed [CALC_W-1:0] base;
  logic signed [CALC_W-1:0] mu_s;
  logic signed [CALC_W-1:0] diff;
  logic signed [EST_W-1:0] est_sat;
  logic [EST_W:0]          q_mag;
  logic [EST_W:0]          q_shift;
  logic signed [EST_W+1:0] q_trunc;
  logic signed [RG_W-1:0]  trunc_res;
  logic signed [EST_W-1:0] e_s;
  logic                    out_free;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign e_s      = $signed(e_rdata);

  // Register write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      contig_length <= '0;
      read_length   <= '0;
      max_gap_size  <= '0;
      min_gap_size  <= '0;
      mean_insert   <= '0;
      dist_length   <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_CONTIG:   contig_length <= pwdata[15:0];
        REG_READ:     read_length   <= pwdata[15:0];
        REG_MAX_GAP:  max_gap_size  <= pwdata[13:0];
        REG_MIN_GAP:  min_gap_size  <= pwdata[15:0];
        REG_MEAN:     mean_insert   <= pwdata[15:0];
        REG_DIST_LEN: dist_length   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    case (paddr[4:2])
      REG_CONTIG:   prdata = 32'(contig_length);
      REG_READ:     prdata = 32'(read_length);
      REG_MAX_GAP:  prdata = 32'(max_gap_size);
      REG_MIN_GAP:  prdata = 32'(min_gap_size);
      REG_MEAN:     prdata = 32'(mean_insert);
      REG_DIST_LEN: prdata = 32'(dist_length);
      default:      prdata = '0;
    endcase
  end

  // Table length, readable weight range and first window bounds.
  always_comb begin
    len_ext   = CW'(max_gap_size) + CW'(1);
    tab_len   = (len_ext > CW'(GAP_DEPTH)) ? CW'(GAP_DEPTH) : len_ext;
    dist_lim  = (17'(dist_length) > 17'(DIST_DEPTH)) ? 17'(DIST_DEPTH) : 17'(dist_length);
    sum_last  = (17'(contig_length) < dist_lim - 17'd1) ? contig_length
                                                         : 16'(dist_lim - 17'd1);
    sum_empty = (dist_lim == 17'd0) || (read_length > sum_last);
  end

  // Sliding window edges for gap g >= 1.
  always_comb begin
    lo_idx   = IW'(g) - IW'(1) + IW'(read_length);
    hi_idx   = IW'(g) + IW'(contig_length);
    lo_valid = (lo_idx < IW'(dist_lim));
    hi_valid = (hi_idx < IW'(dist_lim));
  end

  // Window mean: magnitude of the weighted sum, scaled and saturated.
  always_comb begin
    num_mag = wnum[WNUM_W-1] ? (~wnum + WNUM_W'(1)) : wnum;
    den_pos = !wsum[WSUM_W-1] && (wsum != '0);
    mu_sat  = (div_quot > (NW'(1) << MU_EXP)) ? ((MU_EXP+1)'(1) << MU_EXP)
                                               : div_quot[MU_EXP:0];
  end

  // Estimate = (g + mean) scaled minus mu, saturated to 32 bits.
  always_comb begin
    base = CALC_W'((CALC_W'(g) + CALC_W'(mean_insert)) << FRAC_BITS);
    mu_s = mu_neg ? -$signed(CALC_W'(mu_mag)) : $signed(CALC_W'(mu_mag));
    diff = base - mu_s;
    if (diff > $signed(CALC_W'(32'h7FFF_FFFF)))
      est_sat = 32'sh7FFF_FFFF;
    else if (diff < -$signed(CALC_W'(33'h1_0000_0000) >>> 1))
      est_sat = -32'sh7FFF_FFFF - 32'sd1;
    else
      est_sat = EST_W'(diff);
  end

  // Query gap truncated toward zero and saturated to the result width.
  always_comb begin
    q_mag   = in_data.query_gap[EST_W-1] ? (EST_W+1)'(-$signed({1'b1, in_data.query_gap}))
                                         : (EST_W+1)'(in_data.query_gap);
    q_shift = q_mag >> FRAC_BITS;
    q_trunc = in_data.query_gap[EST_W-1] ? -$signed({1'b0, q_shift}) : $signed({1'b0, q_shift});
    if (q_trunc > $signed((EST_W+2)'(24'h7F_FFFF)))
      trunc_res = 24'sh7F_FFFF;
    else if (q_trunc < -$signed((EST_W+2)'(25'h80_0000)))
      trunc_res = -24'sh7F_FFFF - 24'sd1;
    else
      trunc_res = RG_W'(q_trunc);
  end

  assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q);
  assign mid     = mid_sum[CW:1];

  // Memory ports.
  always_comb begin
    w_we    = in_fire && (in_data.command == CMD_LOAD) &&
              (32'(in_data.weight_index) < 32'(DIST_DEPTH));
    w_waddr = DW'(in_data.weight_index);
    case (state)
      S_SUM_RD: w_raddr = DW'(si);
      S_SL_LO:  w_raddr = DW'(lo_idx);
      S_SL_HI:  w_raddr = DW'(hi_idx);
      default:  w_raddr = '0;
    endcase
    e_we = (state == S_EST_WR);
    case (state)
      S_Q_SCAN_RD: e_raddr = GW'(ci);
      S_Q_SRCH_RD: e_raddr = GW'(mid);
      S_Q_KEY_RD:  e_raddr = GW'(mid);
      S_Q_DN_RD:   e_raddr = GW'(ci - CW'(1));
      S_Q_UP_RD:   e_raddr = GW'(ci);
      default:     e_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= in_data.weight_value;
    w_rdata <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[GW'(g)] <= est;
    e_rdata <= emem[e_raddr];
  end

  // Divider requests: window mean during a build, run average in a query.
  always_comb begin
    div_start = 1'b0;
    div_num   = NW'(num_mag) << FRAC_BITS;
    div_den   = wsum;
    if (state == S_EST) begin
      if (g == '0)
        div_start = (contig_length >= min_gap_size) && (wsum != '0);
      else
        div_start = den_pos;
    end else if (state == S_Q_AVG) begin
      div_start = 1'b1;
      div_num   = NW'(run_sum);
      div_den   = WSUM_W'(run_cnt);
    end
  end

  gsct_div #(.NW(NW), .DNW(WSUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      min_est   <= '0;
      max_est   <= '0;
    end else begin
      // A beat taken while the next one is being handed over stays valid.
      if (out_valid && out_ready && state != S_RESP) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd <= in_data.command;
            q   <= in_data.query_gap;
            if (in_data.command == CMD_BUILD) begin
              res     <= '0;
              min_est <= '0;
              max_est <= '0;
              wnum    <= '0;
              wsum    <= '0;
              g       <= '0;
              si      <= read_length;
              state   <= sum_empty ? S_EST : S_SUM_RD;
            end else if (in_data.command == CMD_QUERY) begin
              if (in_data.query_gap < min_est) begin
                res   <= trunc_res;
                state <= S_RESP;
              end else if (in_data.query_gap > max_est) begin
                res   <= trunc_res;
                ci    <= tab_len - CW'(1);
                state <= (tab_len != CW'(1)) ? S_Q_SCAN_RD : S_RESP;
              end else begin
                res   <= '0;
                lo_q  <= '0;
                hi_q  <= tab_len - CW'(1);
                state <= S_Q_SRCH_RD;
              end
            end else begin
              res   <= '0;
              state <= S_RESP;
            end
          end
        end
        // First window: read, multiply and accumulate each weight in turn.
        S_SUM_RD: state <= S_SUM_MUL;
        S_SUM_MUL: begin
          prod_lo <= PW'(si) * PW'(w_rdata);
          wh      <= w_rdata;
          state   <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          wnum <= wnum + WNUM_W'(prod_lo);
          wsum <= wsum + WSUM_W'(wh);
          if (si == sum_last) begin
            state <= S_EST;
          end else begin
            si    <= si + 16'd1;
            state <= S_SUM_RD;
          end
        end
        // Window slide: drop the low edge, add the high edge.
        S_SL_LO: begin
          lo_ok <= lo_valid;
          state <= S_SL_HI;
        end
        S_SL_HI: begin
          wl    <= lo_ok ? w_rdata : 32'd0;
          hi_ok <= hi_valid;
          state <= S_SL_MUL;
        end
        S_SL_MUL: begin
          wh      <= hi_ok ? w_rdata : 32'd0;
          prod_lo <= PW'(lo_idx) * PW'(wl);
          prod_hi <= PW'(hi_idx) * PW'(hi_ok ? w_rdata : 32'd0);
          state   <= S_SL_ACC;
        end
        S_SL_ACC: begin
          wnum  <= wnum - WNUM_W'(prod_lo) + WNUM_W'(prod_hi);
          wsum  <= wsum - WSUM_W'(wl) + WSUM_W'(wh);
          state <= S_EST;
        end
        // Decide how this entry's estimate is formed.
        S_EST: begin
          mu_neg <= wnum[WNUM_W-1];
          if (div_start) begin
            state <= S_DIV_WAIT;
          end else if (g == '0 && contig_length >= min_gap_size) begin
            mu_mag <= '0;
            state  <= S_EST_CALC;
          end else begin
            est   <= '0;
            state <= S_EST_WR;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            mu_mag <= mu_sat;
            state  <= S_EST_CALC;
          end
        end
        S_EST_CALC: begin
          est   <= est_sat;
          state <= S_EST_WR;
        end
        S_EST_WR: begin
          if (est > max_est) max_est <= est;
          if (min_est == '0 && est != '0) min_est <= est;
          if (g == tab_len - CW'(1)) begin
            state <= S_RESP;
          end else begin
            g     <= g + CW'(1);
            state <= S_SL_LO;
          end
        end
        // Above the maximum: highest entry with a positive estimate.
        S_Q_SCAN_RD: state <= S_Q_SCAN_CK;
        S_Q_SCAN_CK: begin
          if (e_s > 0) begin
            res   <= RG_W'(ci);
            state <= S_RESP;
          end else if (ci == CW'(1)) begin
            state <= S_RESP;
          end else begin
            ci    <= ci - CW'(1);
            state <= S_Q_SCAN_RD;
          end
        end
        // Halving search.
        S_Q_SRCH_RD: begin
          mid_r <= mid;
          state <= (lo_q == hi_q) ? S_Q_KEY_RD : S_Q_SRCH_CK;
        end
        S_Q_SRCH_CK: begin
          if (e_s == q || mid_r == lo_q || mid_r == hi_q) begin
            state <= S_Q_KEY_RD;
          end else begin
            if (e_s < q) lo_q <= mid_r;
            else         hi_q <= mid_r;
            state <= S_Q_SRCH_RD;
          end
        end
        S_Q_KEY_RD: begin
          mid_r <= mid;
          state <= S_Q_KEY_CK;
        end
        S_Q_KEY_CK: begin
          key     <= e_rdata;
          run_sum <= SW'(mid_r);
          run_cnt <= CW'(1);
          ci      <= mid_r;
          state   <= S_Q_DN_RD;
        end
        // Walk the run of equal estimates downward, then upward.
        S_Q_DN_RD: begin
          if (ci == '0) begin
            ci    <= mid_r + CW'(1);
            state <= S_Q_UP_RD;
          end else begin
            state <= S_Q_DN_CK;
          end
        end
        S_Q_DN_CK: begin
          if (e_rdata == key) begin
            run_cnt <= run_cnt + CW'(1);
            run_sum <= run_sum + SW'(ci - CW'(1));
            ci      <= ci - CW'(1);
            state   <= S_Q_DN_RD;
          end else begin
            ci    <= mid_r + CW'(1);
            state <= S_Q_UP_RD;
          end
        end
        S_Q_UP_RD: state <= (ci >= tab_len) ? S_Q_AVG : S_Q_UP_CK;
        S_Q_UP_CK: begin
          if (e_rdata == key) begin
            run_cnt <= run_cnt + CW'(1);
            run_sum <= run_sum + SW'(ci);
            ci      <= ci + CW'(1);
            state   <= S_Q_UP_RD;
          end else begin
            state <= S_Q_AVG;
          end
        end
        S_Q_AVG: state <= S_Q_AVG_WAIT;
        S_Q_AVG_WAIT: begin
          if (div_done) begin
            res   <= RG_W'(div_quot);
            state <= S_RESP;
          end
        end
        // Hand the result beat to the output register.
        S_RESP: begin
          if (out_free) begin
            out_data.done_kind <= cmd;
            out_data.real_gap  <= res;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/gsct_div.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle, shared by the build
// (window mean) and the query (run average). Uses no package items.
module gsct_div #(
  parameter int NW  = 72,
  parameter int DNW = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  output logic           done,
  output logic [NW-1:0]  quot
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DNW-1:0]   rem;
  logic [DNW-1:0]   dsr;
  logic [DNW:0]     trial;
  logic [DNW:0]     diff;
  logic             ge;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem, quot[NW-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsr  <= den;
      quot <= num;
    end else if (busy) begin
      rem  <= ge ? diff[DNW-1:0] : trial[DNW-1:0];
      quot <= {quot[NW-2:0], ge};
    end
  end

endmodule

// File: src/gsct_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the gap size correction table, bound to the top level.
// Depends on gsct_pkg and gap_size_correction_table_top.
module gsct_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gsct_pkg::gsct_out_t out_data
);
  import gsct_pkg::*;

  logic [1:0] pend;

  // Beats accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   pend <= pend + 2'd1;
        2'b01:   pend <= pend - 2'd1;
        default: pend <= pend;
      endcase
    end
  end

  // No result is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Every result belongs to an accepted input beat.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("result beat without an input beat");

  // Only queries carry a real gap.
  a_kind_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_kind != CMD_QUERY |-> out_data.real_gap == '0)
    else $error("nonzero real gap on a non-query result");

endmodule

bind gap_size_correction_table_top gsct_checker u_gsct_checker (.*);
